/* src/acfr_pkg.sv */
`timescale 1ns / 1ps

package acfr_pkg;

    localparam int MAX_FRAME = 64;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int LIM_W     = 7;
    localparam int CHR_W     = 7;
    localparam int SUM_W     = $clog2(MAX_FRAME * (1 << CHR_W));
    localparam int CMP_W     = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_SEP   = 8'h7C;
    localparam logic [7:0] CH_LOW   = 8'h20;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(64);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECIDE,
        ST_SUM,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMPTY
    } state_t;

    // (x mod 90) + ' ' for an 8-bit x; x < 3 * 90 so two compare/subtracts do it
    function automatic logic [CHR_W-1:0] check_char(input logic [7:0] x);
        logic [7:0] r;
        begin
            if (x >= 8'd180) begin
                r = x - 8'd180;
            end else if (x >= 8'd90) begin
                r = x - 8'd90;
            end else begin
                r = x;
            end
            check_char = CHR_W'(r + CH_LOW);
        end
    endfunction

endpackage

/* src/ascii_command_frame_receiver_core.sv */
`timescale 1ns / 1ps

// ASCII command frame receiver. Bytes come in on the s_ channel, one item
// per cycle while the block is idle; '{' opens a frame, bytes outside
// 0x20..0x7D or a frame longer than cfg buffer_limit (capped at MAX_FRAME)
// abort it. On '}' the frame is resolved from the frame memory (a
// synchronous RAM with one write and one read port, registered read), and
// s_ready stays low until resolution and emission are done: fetch the
// separator, name and check bytes, then for the checked form {body|n?ab} a
// sum walk over indices 1..len-5 and a check step, then emit the body
// characters on the m_ channel (one per cycle with m_ready high, or one
// empty-body result). The last result may still wait in the output
// register while new bytes are taken.
module ascii_command_frame_receiver_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [acfr_pkg::LIM_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [acfr_pkg::CHR_W-1:0]    m_command_name,
    output logic [acfr_pkg::CHR_W-1:0]    m_body_char,
    output logic                          m_body_empty,
    output logic                          m_had_check,
    output logic                          m_last_char
);
    import acfr_pkg::*;

    // frame memory
    logic [CHR_W-1:0]  mem [MAX_FRAME];
    logic [CHR_W-1:0]  mem_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CHR_W-1:0]  mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    // control / datapath registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  body_len_reg, body_len_next;
    logic [1:0]        ph_reg, ph_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [LIM_W-1:0]  limit_reg;
    logic [CHR_W-1:0]  v6_reg, v6_next;
    logic [CHR_W-1:0]  v5_reg, v5_next;
    logic [CHR_W-1:0]  v3_reg, v3_next;
    logic [CHR_W-1:0]  v2_reg, v2_next;
    logic [CHR_W-1:0]  name_reg, name_next;
    logic              checked_reg, checked_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [CHR_W-1:0]  m_name_reg, m_name_next;
    logic [CHR_W-1:0]  m_char_reg, m_char_next;
    logic              m_empty_reg, m_empty_next;
    logic              m_chk_reg, m_chk_next;
    logic              m_last_reg, m_last_next;

    logic              in_acc;
    logic              out_free;
    logic              full;
    logic              bad_byte;
    logic [CMP_W-1:0]  limit_eff;
    logic [CNT_W-1:0]  len_new;
    logic [CNT_W-1:0]  sum_end;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign limit_eff = (CMP_W'(limit_reg) > CMP_W'(MAX_FRAME)) ? CMP_W'(MAX_FRAME)
                                                                : CMP_W'(limit_reg);
    assign full      = (CMP_W'(count_reg) >= limit_eff) ||
                       (CMP_W'(count_reg) >= CMP_W'(MAX_FRAME));
    assign bad_byte  = (s_rx_byte < CH_LOW) || (s_rx_byte > CH_CLOSE);
    assign len_new   = count_reg + CNT_W'(1);
    assign sum_end   = len_reg - CNT_W'(5);   // last index summed

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        body_len_next = body_len_reg;
        ph_next       = ph_reg;
        rd_pend_next  = rd_pend_reg;
        sum_next      = sum_reg;
        v6_next       = v6_reg;
        v5_next       = v5_reg;
        v3_next       = v3_reg;
        v2_next       = v2_reg;
        name_next     = name_reg;
        checked_next  = checked_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_name_next   = m_name_reg;
        m_char_next   = m_char_reg;
        m_empty_next  = m_empty_reg;
        m_chk_next    = m_chk_reg;
        m_last_next   = m_last_reg;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = s_rx_byte[CHR_W-1:0];
        mem_re        = 1'b0;
        mem_ra        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    priority if (s_rx_byte == CH_OPEN) begin
                        mem_we     = 1'b1;
                        mem_wa     = '0;
                        count_next = CNT_W'(1);
                    end else if (count_reg == '0) begin
                        count_next = count_reg;   // no frame open: ignore
                    end else if (full || bad_byte) begin
                        count_next = '0;
                    end else begin
                        mem_we     = 1'b1;
                        mem_wa     = count_reg[ADDR_W-1:0];
                        count_next = len_new;
                        if (s_rx_byte == CH_CLOSE) begin
                            count_next = '0;
                            len_next   = len_new;
                            ph_next    = '0;
                            if (len_new >= CNT_W'(5)) begin
                                state_next = ST_FETCH;
                            end
                        end
                    end
                end
            end

            // read len-6, len-5, len-3, len-2; each value is registered in mem_q and taken in the following phase
            ST_FETCH: begin
                mem_re  = 1'b1;
                ph_next = ph_reg + 2'd1;
                unique case (ph_reg)
                    2'd0: mem_ra = ADDR_W'(len_reg - CNT_W'(6));
                    2'd1: begin
                        mem_ra  = ADDR_W'(len_reg - CNT_W'(5));
                        v6_next = mem_q;
                    end
                    2'd2: begin
                        mem_ra  = ADDR_W'(len_reg - CNT_W'(3));
                        v5_next = mem_q;
                    end
                    default: begin
                        mem_ra     = ADDR_W'(len_reg - CNT_W'(2));
                        v3_next    = mem_q;
                        state_next = ST_DECIDE;
                    end
                endcase
            end

            ST_DECIDE: begin
                v2_next = mem_q;
                // checked form takes priority; index 0 holds '{' so it implies len >= 7
                priority if ((len_reg >= CNT_W'(6)) && (v6_reg == CH_SEP[CHR_W-1:0])) begin
                    name_next    = v5_reg;
                    idx_next     = CNT_W'(1);
                    sum_next     = '0;
                    rd_pend_next = 1'b0;
                    state_next   = ST_SUM;
                end else if (v3_reg == CH_SEP[CHR_W-1:0]) begin
                    name_next     = mem_q;
                    checked_next  = 1'b0;
                    body_len_next = len_reg - CNT_W'(4);
                    idx_next      = CNT_W'(1);
                    state_next    = ST_EMIT_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            // sum over indices 1 .. len-5
            ST_SUM: begin
                if (rd_pend_reg) begin
                    sum_next = sum_reg + SUM_W'(mem_q);
                end
                if (idx_reg <= sum_end) begin
                    mem_re       = 1'b1;
                    mem_ra       = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg) begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK: begin
                if ((check_char(sum_reg[7:0]) == v3_reg) &&
                    (check_char(8'(sum_reg >> 8)) == v2_reg)) begin
                    checked_next  = 1'b1;
                    body_len_next = len_reg - CNT_W'(7);
                    idx_next      = CNT_W'(1);
                    state_next    = (len_reg == CNT_W'(7)) ? ST_EMPTY : ST_EMIT_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT_RD: begin
                mem_re     = 1'b1;
                mem_ra     = idx_reg[ADDR_W-1:0];
                state_next = ST_EMIT_LD;
            end

            // mem_q holds body[idx] until the next read; prefetch idx+1 on load
            ST_EMIT_LD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_name_next  = name_reg;
                    m_char_next  = mem_q;
                    m_empty_next = 1'b0;
                    m_chk_next   = checked_reg;
                    m_last_next  = (idx_reg == body_len_reg);
                    if (idx_reg == body_len_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        mem_re   = 1'b1;
                        mem_ra   = ADDR_W'(idx_reg + CNT_W'(1));
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end

            ST_EMPTY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_name_next  = name_reg;
                    m_char_next  = '0;
                    m_empty_next = 1'b1;
                    m_chk_next   = checked_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_q <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            limit_reg   <= LIMIT_RESET;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        body_len_reg <= body_len_next;
        ph_reg       <= ph_next;
        sum_reg      <= sum_next;
        v6_reg       <= v6_next;
        v5_reg       <= v5_next;
        v3_reg       <= v3_next;
        v2_reg       <= v2_next;
        name_reg     <= name_next;
        checked_reg  <= checked_next;
        m_name_reg   <= m_name_next;
        m_char_reg   <= m_char_next;
        m_empty_reg  <= m_empty_next;
        m_chk_reg    <= m_chk_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_command_name = m_name_reg;
    assign m_body_char    = m_char_reg;
    assign m_body_empty   = m_empty_reg;
    assign m_had_check    = m_chk_reg;
    assign m_last_char    = m_last_reg;

    // frame fill never passes the memory depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_FRAME))
        else $error("frame count beyond memory depth");

    // an empty-body result is a single, final result with a zero character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_body_empty) |-> (m_last_char && (m_body_char == '0)))
        else $error("empty-body result malformed");

    // emission index stays inside the body
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_LD) |->
            ((idx_reg >= CNT_W'(1)) && (idx_reg <= body_len_reg)))
        else $error("body index out of range");

    // after a sum or check state, no byte is taken unless the block is back in idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM || state_reg == ST_CHECK) |=> !(s_valid && s_ready) ||
            (state_reg == ST_IDLE))
        else $error("input accepted during resolve");

endmodule

/* sim/ascii_command_frame_receiver_core_tb.sv */
`timescale 1ns / 1ps

// Testbench for the ASCII command frame receiver.
//
// Bytes go in as s_ items. A scoreboard object keeps its own copy of the
// frame buffer, the open-frame length and the buffer limit. From that copy it
// works out the result items that each accepted byte must cause. Result items
// on the m_ channel are checked field by field against the oldest expected
// one, in order.
//
// The run goes through several phases. Each phase has its own buffer limit:
// the reset value, above the cap, the smallest legal value, zero and a few in
// between. Each phase also has its own throttling mix on the two channels.
// The limit is rewritten only once the block has drained and settled.
module ascii_command_frame_receiver_core_tb;

    import acfr_pkg::*;

    localparam int CHECK_MOD     = 90;
    localparam int NUM_PHASES    = 7;
    localparam int RANDOM_BYTES  = 6;       // random bytes per phase, roughly
    // Worst case after the closing brace: fetch, a sum walk over up to 59 bytes,
    // check, then emission of up to 60 body characters. SETTLE_CYCLES covers that with margin.
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [CHR_W-1:0] name;
        logic [CHR_W-1:0] ch;
        logic             empty;
        logic             chk;
        logic             last;
    } cmd_result_t;

    // Scoreboard: tracks frame assembly and queues the result items due.
    class frame_scoreboard;
        logic [CHR_W-1:0] frame_mem [MAX_FRAME];
        int unsigned      open_len;
        logic [LIM_W-1:0] limit_reg;
        cmd_result_t      expected_q[$];
        int unsigned      mismatches;
        int unsigned      results_checked;
        int unsigned      frames_accepted;

        function new();
            open_len        = 0;
            limit_reg       = LIMIT_RESET;
            mismatches      = 0;
            results_checked = 0;
            frames_accepted = 0;
        endfunction

        // One check character: low byte of the sum, mod 90, moved into the
        // printable range.
        static function logic [CHR_W-1:0] sum_digit(int unsigned s);
            return CHR_W'((s & 32'h00ff) % CHECK_MOD + int'(CH_LOW));
        endfunction

        function void set_limit(logic [LIM_W-1:0] v);
            limit_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Closing brace seen; len counts both braces.
        function void resolve_frame(int unsigned len);
            logic [CHR_W-1:0] name;
            logic             chk;
            int unsigned      body_len;
            int unsigned      sum;
            int unsigned      i;
            cmd_result_t      r;
            if (len < 5) return;
            chk = 1'b0;
            // Checked form has priority. With six bytes, index 0 is the
            // opening brace, so this test can only pass from seven up.
            if (len >= 6 && frame_mem[len-6] == CH_SEP[CHR_W-1:0]) begin
                name = frame_mem[len-5];
                sum  = 0;
                for (i = 1; i < len - 4; i++) sum += frame_mem[i];
                // The separator before the check characters is never examined.
                if (sum_digit(sum) != frame_mem[len-3] ||
                    sum_digit(sum >> 8) != frame_mem[len-2]) return;
                chk      = 1'b1;
                body_len = len - 7;
            end else if (frame_mem[len-3] == CH_SEP[CHR_W-1:0]) begin
                name     = frame_mem[len-2];
                body_len = len - 4;
            end else begin
                return;
            end
            frames_accepted++;
            if (body_len == 0) begin
                r = '{name: name, ch: '0, empty: 1'b1, chk: chk, last: 1'b1};
                expected_q.push_back(r);
                return;
            end
            for (i = 0; i < body_len; i++) begin
                r = '{name: name, ch: frame_mem[1+i], empty: 1'b0, chk: chk,
                      last: (i + 1 == body_len)};
                expected_q.push_back(r);
            end
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned lim;
            lim = (limit_reg > MAX_FRAME) ? MAX_FRAME : limit_reg;
            // An opening brace always starts over, even inside a frame.
            if (b == CH_OPEN) begin
                frame_mem[0] = b[CHR_W-1:0];
                open_len     = 1;
                return;
            end
            if (open_len == 0) return;                  // no frame open: ignored
            if (open_len >= lim || open_len >= MAX_FRAME) begin
                open_len = 0;                           // full: byte dropped, abort
                return;
            end
            if (b < CH_LOW || b > CH_CLOSE) begin
                open_len = 0;                           // bad byte: abort
                return;
            end
            frame_mem[open_len] = b[CHR_W-1:0];
            open_len++;
            if (b == CH_CLOSE) begin
                resolve_frame(open_len);
                open_len = 0;
            end
        endfunction

        function void compare_field(string field, logic [CHR_W-1:0] want,
                                    logic [CHR_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(logic [CHR_W-1:0] name, logic [CHR_W-1:0] ch,
                                   logic empty, logic chk, logic last);
            cmd_result_t want;
            results_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result item, expected none, actual name %0h char %0h",
                         $time, name, ch);
                return;
            end
            want = expected_q.pop_front();
            compare_field("command_name", want.name, name);
            compare_field("body_char", want.ch, ch);
            compare_field("body_empty", CHR_W'(want.empty), CHR_W'(empty));
            compare_field("had_check", CHR_W'(want.chk), CHR_W'(chk));
            compare_field("last_char", CHR_W'(want.last), CHR_W'(last));
        endfunction
    endclass

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [LIM_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic [7:0]       s_rx_byte   = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic [CHR_W-1:0] m_command_name;
    logic [CHR_W-1:0] m_body_char;
    logic             m_body_empty;
    logic             m_had_check;
    logic             m_last_char;

    frame_scoreboard  sb;
    logic [7:0]       stim_q[$];      // bytes of the current phase, in send order
    int               idle_pct  = 0;  // sender gap chance per cycle, percent
    int               stall_pct = 0;  // receiver stall chance per cycle, percent
    int unsigned      bytes_sent = 0;

    ascii_command_frame_receiver_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command_name (m_command_name),
        .m_body_char    (m_body_char),
        .m_body_empty   (m_body_empty),
        .m_had_check    (m_had_check),
        .m_last_char    (m_last_char)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver throttling: a new ready decision every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Result monitor. m_ready is the value from before this edge, because it
    // is driven with a nonblocking assignment.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_command_name, m_body_char, m_body_empty,
                            m_had_check, m_last_char);
        end
    end

    // Printable frame content. Braces are kept out so the frame stays whole.
    function automatic logic [7:0] rand_text();
        logic [7:0] c;
        do c = 8'($urandom_range(32, 125));
        while (c == CH_OPEN || c == CH_CLOSE);
        return c;
    endfunction

    // Append {body|n} or {body|n?ab}. The body and name are random. The
    // corrupt flag puts a wrong first check character into the frame.
    function automatic void append_frame(int body_len, bit checked, bit corrupt);
        int unsigned      sum;
        logic [7:0]       c;
        logic [CHR_W-1:0] a;
        sum = 0;
        stim_q.push_back(CH_OPEN);
        repeat (body_len) begin
            c = rand_text();
            stim_q.push_back(c);
            sum += c;
        end
        stim_q.push_back(CH_SEP);
        sum += CH_SEP;
        c = rand_text();
        stim_q.push_back(c);
        sum += c;
        if (checked) begin
            stim_q.push_back(rand_text());      // separator byte, not examined
            a = frame_scoreboard::sum_digit(sum);
            if (corrupt) a = (a == CH_LOW[CHR_W-1:0]) ? a + 1'b1 : a - 1'b1;
            stim_q.push_back({1'b0, a});
            stim_q.push_back({1'b0, frame_scoreboard::sum_digit(sum >> 8)});
        end
        stim_q.push_back(CH_CLOSE);
    endfunction

    // Random mix: mostly well-formed frames, with the broken kinds and noise
    // mixed in.
    function automatic void build_random(int lim, int unsigned target);
        int unsigned kind;
        int unsigned start;
        int          blen;
        while (stim_q.size() < target) begin
            kind = $urandom_range(0, 99);
            // Bodies are mostly short; once in a while as long as the limit allows.
            blen = ($urandom_range(0, 99) < 8 && lim > 12) ?
                   $urandom_range(0, lim - 4) : $urandom_range(0, 8);
            if (kind < 40) begin
                append_frame(blen, 1'b0, 1'b0);
            end else if (kind < 75) begin
                append_frame(blen, 1'b1, 1'b0);
            end else if (kind < 82) begin
                append_frame(blen, 1'b1, 1'b1);
            end else if (kind < 88) begin
                // Replace one byte inside the frame with an out-of-range one.
                start = stim_q.size();
                append_frame(blen, 1'($urandom_range(0, 1)), 1'b0);
                stim_q[$urandom_range(start + 1, stim_q.size() - 1)] =
                    $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                         : 8'($urandom_range(126, 255));
            end else if (kind < 93) begin
                // Longer than the limit: aborted by the byte that overflows it.
                append_frame(((lim > 3) ? lim - 3 : 0) + $urandom_range(0, 3), 1'b0, 1'b0);
            end else if (kind < 97) begin
                // Unfinished frame; the next opening brace starts over.
                stim_q.push_back(CH_OPEN);
                repeat ($urandom_range(0, 4)) stim_q.push_back(rand_text());
            end else begin
                repeat ($urandom_range(1, 3)) stim_q.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 15) stim_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Present one item and hold it until it is accepted. s_valid drops only
    // when a gap comes up, so each step gets at most one assignment to it.
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic write_limit(logic [LIM_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(v);
    endtask

    initial begin
        logic [LIM_W-1:0] phase_limit [NUM_PHASES];
        int               lim;
        int               ph;
        sb = new();
        // Reset value, above the cap, smallest legal value, mid, zero (every
        // frame aborted), the cap exactly, then one random setting.
        phase_limit = '{LIMIT_RESET, 7'd127, 7'd5, 7'd12, 7'd0, 7'd64,
                        LIM_W'($urandom_range(5, 64))};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            // Throttling mix: none, sender gaps, receiver stalls, both.
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            // Phase 0 runs with the limit it has after reset.
            if (ph != 0) write_limit(phase_limit[ph]);
            lim = (phase_limit[ph] > MAX_FRAME) ? MAX_FRAME : phase_limit[ph];
            stim_q.delete();

            if (ph == 0) begin
                stim_q.push_back(8'h71);               // no frame open: ignored
                append_frame(0, 1'b1, 1'b0);           // checked form, empty body
                append_frame(1, 1'b0, 1'b0);           // plain form, one char
                append_frame(0, 1'b0, 1'b0);           // four bytes: too short
                append_frame(2, 1'b1, 1'b1);           // check fails
                stim_q.push_back(CH_OPEN);             // top bit set aborts
                stim_q.push_back(8'hFF);
                stim_q.push_back(CH_OPEN);             // just below the printable range
                stim_q.push_back(8'h1F);
                stim_q.push_back(CH_OPEN);             // just above the close brace
                stim_q.push_back(8'h7E);
            end
            // At the smallest limit and at the cap, a plain frame that fills
            // the buffer exactly.
            if (ph == 2 || ph == 5) append_frame(lim - 4, 1'b0, 1'b0);
            build_random(lim, stim_q.size() + RANDOM_BYTES);

            foreach (stim_q[i]) send_byte(stim_q[i]);
            s_valid <= 1'b0;

            // Drain, then give the block time to finish a frame that emits nothing.
            while (sb.pending() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end

        $display("sent %0d bytes under %0d buffer limit settings, idle and stall mixes",
                 bytes_sent, NUM_PHASES);
        $display("checked %0d result items from %0d accepted frames, %0d mismatches",
                 sb.results_checked, sb.frames_accepted, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
src/acfr_pkg.sv
src/ascii_command_frame_receiver_core.sv
sim/ascii_command_frame_receiver_core_tb.sv
